### design/brrc_pkg.sv
// ----------------------------------------------------------------------------
// brrc_pkg
// Shared types and constants of the base-relocation range checker.
// ----------------------------------------------------------------------------
package brrc_pkg;

  localparam int MaxRanges   = 32;
  localparam int SlotW       = $clog2(MaxRanges);
  localparam int CountW      = 6;
  localparam int PageBytes   = 4096;
  localparam int PageSpan    = PageBytes + 7;
  localparam int QueueDepth  = 2;

  localparam logic [1:0] MODE_LOAD   = 2'd0;
  localparam logic [1:0] MODE_HEADER = 2'd1;
  localparam logic [1:0] MODE_ENTRY  = 2'd2;
  localparam logic [1:0] MODE_START  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_BAD_BLOCK = 3'd1;
  localparam logic [2:0] ST_MISALIGN  = 3'd2;
  localparam logic [2:0] ST_BAD_TYPE  = 3'd3;
  localparam logic [2:0] ST_OUTSIDE   = 3'd4;
  localparam logic [2:0] ST_CODE_HIT  = 3'd5;
  localparam logic [2:0] ST_STRAY     = 3'd6;
  localparam logic [2:0] ST_EARLY_HDR = 3'd7;

  localparam logic [3:0] TYPE_PAD    = 4'd0;
  localparam logic [3:0] TYPE_HIGHLOW = 4'd3;
  localparam logic [3:0] TYPE_DIR64  = 4'd10;

  localparam logic [1:0] CFG_IMAGE = 2'd0;
  localparam logic [1:0] CFG_DIR   = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [4:0]  range_slot;
    logic [31:0] range_base;
    logic [13:0] range_bytes;
    logic [31:0] page_base;
    logic [31:0] block_bytes;
    logic [15:0] entry_word;
  } in_beat_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        block_relevant;
    logic        block_finished;
    logic        directory_finished;
    logic [28:0] blocks_seen;
    logic [28:0] blocks_skipped;
    logic [30:0] entries_seen;
  } out_beat_t;

  // Classified beat handed from the front to the back.
  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] page_base;
    logic [31:0] block_bytes;
    logic        page_hit;     // header page span overlaps a range
    logic [3:0]  etype;
    logic [11:0] eoffs;
  } work_t;

  // True when [a, a+alen) and [b, b+blen) share a byte; lengths nonzero.
  function automatic logic spans_meet(logic [32:0] a, logic [13:0] alen,
                                      logic [31:0] b, logic [13:0] blen);
    logic [33:0] a_end;
    logic [33:0] b_end;
    begin
      a_end = {1'b0, a} + {20'd0, alen};
      b_end = {2'b0, b} + {20'd0, blen};
      spans_meet = (alen != '0) && (blen != '0) &&
                   ({1'b0, a} < b_end) && ({2'b0, b} < a_end);
    end
  endfunction

endpackage

### design/base_relocation_range_checker.sv
// ----------------------------------------------------------------------------
// base_relocation_range_checker
// Scans a base-relocation directory against a table of protected ranges.
// ----------------------------------------------------------------------------
// Each input beat yields one result beat. A beat passes a front stage that
// writes the range table and compares header pages against all ranges in
// parallel, then a two-entry queue, then a back stage that updates the scan
// state and registers the result. Throughput is one beat per cycle while the
// output is not stalled, except that a load beat waits until the queue is
// empty and so stalls behind a queued beat. An accepted beat passes the queue
// and then the result register before its result is valid. There is no
// clearing pass.
module base_relocation_range_checker (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  brrc_pkg::in_beat_t    in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output brrc_pkg::out_beat_t   out_data,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [31:0]           cfg_data
);

  logic [31:0] image_r, dir_r;
  logic [brrc_pkg::CountW-1:0] count_r;
  logic q_pop, q_valid, site_hit;
  brrc_pkg::work_t q_head;
  logic [32:0] site;
  logic [13:0] site_len;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_r <= 32'h8000_0000;
      dir_r   <= 32'd8;
      count_r <= 6'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        brrc_pkg::CFG_IMAGE: image_r <= cfg_data;
        brrc_pkg::CFG_DIR:   dir_r   <= cfg_data;
        brrc_pkg::CFG_COUNT: count_r <= cfg_data[brrc_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  brrc_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .range_count(count_r), .q_pop, .q_valid, .q_head,
    .site, .site_len, .site_hit
  );

  brrc_back u_back (
    .clk, .rst_n, .q_valid, .q_head, .q_pop,
    .image_bytes(image_r), .directory_bytes(dir_r),
    .site, .site_len, .site_hit,
    .out_valid, .out_ready, .out_data
  );

endmodule

### design/brrc_front.sv
// ----------------------------------------------------------------------------
// brrc_front
// Holds the range table, writes loads into it and classifies header pages
// against all ranges, pushing work beats into a short queue.
// ----------------------------------------------------------------------------
module brrc_front (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  brrc_pkg::in_beat_t               in_data,
  input  logic [brrc_pkg::CountW-1:0]      range_count,
  input  logic                             q_pop,
  output logic                             q_valid,
  output brrc_pkg::work_t                  q_head,
  // Site check for the back end: compares a site against the table.
  input  logic [32:0]                      site,
  input  logic [13:0]                      site_len,
  output logic                             site_hit
);

  logic [31:0] base_r [brrc_pkg::MaxRanges];
  logic [13:0] len_r  [brrc_pkg::MaxRanges];
  brrc_pkg::work_t q_r [brrc_pkg::QueueDepth];
  logic [1:0] cnt_r, cnt_nxt;
  logic       wp_r, rp_r;
  logic       page_hit;
  brrc_pkg::work_t w;

  // Parallel compare cells over the table, limited to the live count.
  always_comb begin
    page_hit = 1'b0;
    site_hit = 1'b0;
    for (int i = 0; i < brrc_pkg::MaxRanges; i++) begin
      if (i < int'(range_count)) begin
        if (brrc_pkg::spans_meet({1'b0, in_data.page_base},
                                 14'(brrc_pkg::PageSpan), base_r[i], len_r[i]))
          page_hit = 1'b1;
        if (brrc_pkg::spans_meet(site, site_len, base_r[i], len_r[i]))
          site_hit = 1'b1;
      end
    end
  end

  // A load beat waits for an empty queue, so that queued entries check their
  // sites against the table as it stood when they arrived.
  assign in_ready = (cnt_r != 2'(brrc_pkg::QueueDepth)) &&
                    !((in_data.mode == brrc_pkg::MODE_LOAD) && q_valid);

  always_comb begin
    w.mode        = in_data.mode;
    w.page_base   = in_data.page_base;
    w.block_bytes = in_data.block_bytes;
    w.page_hit    = page_hit;
    w.etype       = in_data.entry_word[15:12];
    w.eoffs       = in_data.entry_word[11:0];
  end

  // Table writes; load beats still go through the queue to produce a result.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready && in_data.mode == brrc_pkg::MODE_LOAD) begin
      base_r[in_data.range_slot[brrc_pkg::SlotW-1:0]] <= in_data.range_base;
      len_r[in_data.range_slot[brrc_pkg::SlotW-1:0]]  <= in_data.range_bytes;
    end
    if (in_valid && in_ready) q_r[wp_r] <= w;
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if ((in_valid && in_ready) && !q_pop) cnt_nxt = cnt_r + 2'd1;
    else if (!(in_valid && in_ready) && q_pop) cnt_nxt = cnt_r - 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_valid && in_ready) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
    end
  end

  assign q_valid = (cnt_r != 2'd0);
  assign q_head  = q_r[rp_r];

  // Queue never exceeds its depth and never pops when empty.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 2'(brrc_pkg::QueueDepth)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("queue underflow");
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'(brrc_pkg::QueueDepth)) |-> !in_ready) else $error("full accept");

endmodule

### design/brrc_back.sv
// ----------------------------------------------------------------------------
// brrc_back
// Carries out queued beats: scan state, checks, counters and result register.
// ----------------------------------------------------------------------------
module brrc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  input  brrc_pkg::work_t             q_head,
  output logic                        q_pop,
  input  logic [31:0]                 image_bytes,
  input  logic [31:0]                 directory_bytes,
  output logic [32:0]                 site,
  output logic [13:0]                 site_len,
  input  logic                        site_hit,
  output logic                        out_valid,
  input  logic                        out_ready,
  output brrc_pkg::out_beat_t         out_data
);

  logic [31:0] page_r, page_nxt, rem_r, rem_nxt, off_r, off_nxt;
  logic        rel_r, rel_nxt;
  logic [2:0]  err_r, err_nxt;
  logic [28:0] blk_r, blk_nxt, skip_r, skip_nxt;
  logic [30:0] ent_r, ent_nxt;
  logic        ovalid_r;
  brrc_pkg::out_beat_t odata_r;
  logic [31:0] left;
  logic [32:0] lim;

  assign q_pop = q_valid && (!ovalid_r || out_ready);
  assign site     = {1'b0, page_r} + {21'd0, q_head.eoffs};
  assign site_len = (q_head.etype == brrc_pkg::TYPE_DIR64) ? 14'd8 : 14'd4;
  assign left = (off_r >= directory_bytes) ? 32'd0 : directory_bytes - off_r;
  assign lim  = {1'b0, image_bytes} - {19'd0, site_len};

  always_comb begin
    page_nxt = page_r; rem_nxt = rem_r; off_nxt = off_r; rel_nxt = rel_r;
    err_nxt = err_r; blk_nxt = blk_r; skip_nxt = skip_r; ent_nxt = ent_r;
    if (q_head.mode == brrc_pkg::MODE_START) begin
      page_nxt = '0; rem_nxt = '0; off_nxt = '0; rel_nxt = 1'b0;
      err_nxt = brrc_pkg::ST_OK; blk_nxt = '0; skip_nxt = '0; ent_nxt = '0;
    end else if (err_r == brrc_pkg::ST_OK && q_head.mode == brrc_pkg::MODE_HEADER) begin
      if (rem_r != '0) err_nxt = brrc_pkg::ST_EARLY_HDR;
      else if (off_r[1:0] != 2'd0) err_nxt = brrc_pkg::ST_MISALIGN;
      else if (q_head.page_base[11:0] != '0 || q_head.page_base >= image_bytes ||
               q_head.block_bytes < 32'd8 || q_head.block_bytes[0] ||
               q_head.block_bytes > left)
        err_nxt = brrc_pkg::ST_BAD_BLOCK;
      else begin
        blk_nxt  = (&blk_r) ? blk_r : blk_r + 29'd1;
        page_nxt = q_head.page_base;
        rel_nxt  = q_head.page_hit;
        if (!q_head.page_hit) skip_nxt = (&skip_r) ? skip_r : skip_r + 29'd1;
        rem_nxt  = q_head.block_bytes - 32'd8;
        off_nxt  = off_r + q_head.block_bytes;
      end
    end else if (err_r == brrc_pkg::ST_OK && q_head.mode == brrc_pkg::MODE_ENTRY) begin
      if (rem_r == '0) err_nxt = brrc_pkg::ST_STRAY;
      else begin
        rem_nxt = rem_r - 32'd2;
        if (rel_r) begin
          ent_nxt = (&ent_r) ? ent_r : ent_r + 31'd1;
          if (q_head.etype == brrc_pkg::TYPE_PAD) begin
            err_nxt = err_r;
          end else if (q_head.etype != brrc_pkg::TYPE_HIGHLOW &&
                       q_head.etype != brrc_pkg::TYPE_DIR64) begin
            err_nxt = brrc_pkg::ST_BAD_TYPE;
          end else if (site > {1'b0, image_bytes} || lim[32] || site > lim) begin
            err_nxt = brrc_pkg::ST_OUTSIDE;
          end else if (site_hit) begin
            err_nxt = brrc_pkg::ST_CODE_HIT;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_r <= '0; rem_r <= '0; off_r <= '0; rel_r <= 1'b0;
      err_r <= brrc_pkg::ST_OK; blk_r <= '0; skip_r <= '0; ent_r <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        page_r <= page_nxt; rem_r <= rem_nxt; off_r <= off_nxt; rel_r <= rel_nxt;
        err_r <= err_nxt; blk_r <= blk_nxt; skip_r <= skip_nxt; ent_r <= ent_nxt;
        ovalid_r <= 1'b1;
      end else if (out_ready) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      odata_r.status             <= err_nxt;
      odata_r.block_relevant     <= rel_nxt;
      odata_r.block_finished     <= (rem_nxt == '0);
      odata_r.directory_finished <= (err_nxt == brrc_pkg::ST_OK) && (rem_nxt == '0) &&
                                    (off_nxt >= directory_bytes);
      odata_r.blocks_seen        <= blk_nxt;
      odata_r.blocks_skipped     <= skip_nxt;
      odata_r.entries_seen       <= ent_nxt;
    end
  end

  assign out_valid = ovalid_r;
  assign out_data  = odata_r;

  // An error stays latched unless a start beat arrives.
  a_latch: assert property (@(posedge clk) disable iff (!rst_n)
    (q_pop && err_r != brrc_pkg::ST_OK && q_head.mode != brrc_pkg::MODE_START)
    |=> $stable(err_r)) else $error("error latch lost");
  a_skip_le: assert property (@(posedge clk) disable iff (!rst_n)
    skip_r <= blk_r) else $error("skips exceed blocks");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ready) |=> ovalid_r) else $error("result dropped");

endmodule
